// ===== rtl/sp2c_pkg.sv =====
package sp2c_pkg;

  // Field widths fixed by the interface.
  localparam int RANGE_W = 24;
  localparam int INDEX_W = 12;
  localparam int ANGLE_W = 16;
  localparam int COORD_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // Datapath widths: CORDIC x and y lanes in Q2.30, range scaled to centimeters.
  localparam int LANE_W = 32;
  localparam int RANGE_CM_W = 31;
  localparam int PROD_W = 64;
  localparam int PROD_SHIFT = 46;

  // Default build parameters.
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 2'd1;

  // Register reset values.
  localparam logic [ANGLE_W-1:0] ANGLE_START_RST = 16'h8000;
  localparam logic [ANGLE_W-1:0] ANGLE_STEP_RST = 16'd182;

  // Ranges at or below one centimeter are replaced by ten meters.
  localparam logic [RANGE_W-1:0] RANGE_MIN_RAW = 24'd655;
  localparam logic [RANGE_W-1:0] RANGE_SUBST_RAW = 24'd655360;
  localparam logic [RANGE_CM_W-1:0] CM_PER_M = 31'd100;
  localparam int OUT_LIMIT = 25600;

  // Quarter and half turn in binary angle units.
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 16'h4000;
  localparam logic [ANGLE_W-1:0] HALF_TURN = 16'h8000;

  // Gain-corrected unit vector, Q2.30.
  localparam logic signed [LANE_W-1:0] CORDIC_ONE_K = 32'sd652032874;

  // Arctangent of 2^-i, 2^32 units per turn, rounded to nearest.
  localparam logic signed [LANE_W-1:0] ATAN_UNITS [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // One sample as it travels down the rotation chain.
  typedef struct packed {
    logic                           vld;
    logic                           flip;
    logic        [RANGE_CM_W-1:0]   range_cm;
    logic signed [LANE_W-1:0]       x;
    logic signed [LANE_W-1:0]       y;
    logic signed [LANE_W-1:0]       z;
  } lane_t;

endpackage

// ===== rtl/scan_polar_to_cartesian_core.sv =====
// Polar-to-Cartesian converter for lidar scans. Each beat on start carries one
// range sample (unsigned Q8.16 meters) and its index in the scan; the block
// returns x and y in whole centimeters, truncated toward zero. The sample
// angle is angle_start + index * angle_step in binary angle units (65536 per
// turn), both set through the cfg port; the user must write them only while
// the block is idle, which the block itself does not enforce. Ranges of
// 0.01 m or less are reported as 10 m. busy is always low: a new sample is
// taken every clock. Each sample passes through one angle stage, one rotation
// cell per CORDIC iteration, a multiply stage and an output register (stage
// counts above 24 build 24 cells). Results are shown for a single cycle and
// cannot be held off, so the receiver must take every out_valid beat.
module scan_polar_to_cartesian_core #(
  parameter int MAX_SAMPLES = sp2c_pkg::MAX_SAMPLES_DEF,
  parameter int CORDIC_STAGES = sp2c_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [sp2c_pkg::RANGE_W-1:0]           in_range_q,
  input  logic [sp2c_pkg::INDEX_W-1:0]           in_sample_index,
  output logic                                   out_valid,
  output logic signed [sp2c_pkg::COORD_W-1:0]    out_x_cm,
  output logic signed [sp2c_pkg::COORD_W-1:0]    out_y_cm,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sp2c_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [sp2c_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int NUM_CELLS = (CORDIC_STAGES > sp2c_pkg::ATAN_ENTRIES) ?
                             sp2c_pkg::ATAN_ENTRIES : CORDIC_STAGES;

  logic [sp2c_pkg::ANGLE_W-1:0] angle_start_r;
  logic [sp2c_pkg::ANGLE_W-1:0] angle_step_r;
  logic                         accept;
  sp2c_pkg::lane_t              lanes [NUM_CELLS+1];

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept = start & ~busy;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r <= sp2c_pkg::ANGLE_START_RST;
      angle_step_r <= sp2c_pkg::ANGLE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sp2c_pkg::REG_ANGLE_START: angle_start_r <= cfg_data;
        sp2c_pkg::REG_ANGLE_STEP:  angle_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Angle, range substitution and start vector.
  sp2c_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .range_q      (in_range_q),
    .sample_index (in_sample_index),
    .angle_start  (angle_start_r),
    .angle_step   (angle_step_r),
    .lane_o       (lanes[0])
  );

  // Row of rotation cells, one CORDIC iteration each.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    sp2c_cell #(
      .STAGE (g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .lane_i (lanes[g]),
      .lane_o (lanes[g+1])
    );
  end

  // Scaling to centimeters and output register.
  sp2c_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .lane_i    (lanes[NUM_CELLS]),
    .out_valid (out_valid),
    .out_x_cm  (out_x_cm),
    .out_y_cm  (out_y_cm)
  );

endmodule

// ===== rtl/sp2c_front.sv =====
module sp2c_front #(
  parameter int MAX_SAMPLES = sp2c_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [sp2c_pkg::RANGE_W-1:0]         range_q,
  input  logic [sp2c_pkg::INDEX_W-1:0]         sample_index,
  input  logic [sp2c_pkg::ANGLE_W-1:0]         angle_start,
  input  logic [sp2c_pkg::ANGLE_W-1:0]         angle_step,
  output sp2c_pkg::lane_t                      lane_o
);

  localparam int IDX_LAST = MAX_SAMPLES - 1;

  logic [sp2c_pkg::INDEX_W-1:0]                 idx_c;
  logic [sp2c_pkg::INDEX_W+sp2c_pkg::ANGLE_W-1:0] step_prod;
  logic [sp2c_pkg::ANGLE_W-1:0]                 ang;
  logic [sp2c_pkg::ANGLE_W-1:0]                 ang_q;
  logic [sp2c_pkg::ANGLE_W-1:0]                 ang_f;
  logic                                         flip;
  logic [sp2c_pkg::RANGE_W-1:0]                 rng;
  sp2c_pkg::lane_t                              lane_nxt;
  sp2c_pkg::lane_t                              lane_r;

  // Sample angle: start plus index times step, wrapped to one turn.
  always_comb begin
    if (int'(sample_index) >= MAX_SAMPLES) begin
      idx_c = sp2c_pkg::INDEX_W'(IDX_LAST);
    end else begin
      idx_c = sample_index;
    end
    step_prod = (sp2c_pkg::INDEX_W + sp2c_pkg::ANGLE_W)'(idx_c) *
                (sp2c_pkg::INDEX_W + sp2c_pkg::ANGLE_W)'(angle_step);
    ang = angle_start + step_prod[sp2c_pkg::ANGLE_W-1:0];
    // Angles in the back half-turn are folded forward; outputs get negated later.
    ang_q = ang + sp2c_pkg::QUARTER_TURN;
    flip = ang_q[sp2c_pkg::ANGLE_W-1];
    ang_f = flip ? (ang ^ sp2c_pkg::HALF_TURN) : ang;
  end

  // Range substitution and scaling to centimeters, then the chain's start vector.
  always_comb begin
    if (range_q <= sp2c_pkg::RANGE_MIN_RAW) begin
      rng = sp2c_pkg::RANGE_SUBST_RAW;
    end else begin
      rng = range_q;
    end
    lane_nxt.vld = accept;
    lane_nxt.flip = flip;
    lane_nxt.range_cm = sp2c_pkg::RANGE_CM_W'(rng) * sp2c_pkg::CM_PER_M;
    lane_nxt.x = sp2c_pkg::CORDIC_ONE_K;
    lane_nxt.y = '0;
    lane_nxt.z = {ang_f, {(sp2c_pkg::LANE_W - sp2c_pkg::ANGLE_W){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r.vld <= lane_nxt.vld;
    end
    lane_r.flip <= lane_nxt.flip;
    lane_r.range_cm <= lane_nxt.range_cm;
    lane_r.x <= lane_nxt.x;
    lane_r.y <= lane_nxt.y;
    lane_r.z <= lane_nxt.z;
  end

  assign lane_o = lane_r;

endmodule

// ===== rtl/sp2c_cell.sv =====
module sp2c_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sp2c_pkg::lane_t lane_i,
  output sp2c_pkg::lane_t lane_o
);

  localparam logic signed [sp2c_pkg::LANE_W-1:0] ATAN = sp2c_pkg::ATAN_UNITS[STAGE];

  logic signed [sp2c_pkg::LANE_W-1:0] xi;
  logic signed [sp2c_pkg::LANE_W-1:0] yi;
  logic signed [sp2c_pkg::LANE_W-1:0] zi;
  logic signed [sp2c_pkg::LANE_W-1:0] dx;
  logic signed [sp2c_pkg::LANE_W-1:0] dy;
  sp2c_pkg::lane_t                    lane_nxt;
  sp2c_pkg::lane_t                    lane_r;

  // One micro-rotation toward zero residual angle; shifts floor.
  always_comb begin
    xi = lane_i.x;
    yi = lane_i.y;
    zi = lane_i.z;
    dx = yi >>> STAGE;
    dy = xi >>> STAGE;
    lane_nxt = lane_i;
    if (!zi[sp2c_pkg::LANE_W-1]) begin
      lane_nxt.x = xi - dx;
      lane_nxt.y = yi + dy;
      lane_nxt.z = zi - ATAN;
    end else begin
      lane_nxt.x = xi + dx;
      lane_nxt.y = yi - dy;
      lane_nxt.z = zi + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.vld <= 1'b0;
    end else begin
      lane_r.vld <= lane_nxt.vld;
    end
    lane_r.flip <= lane_nxt.flip;
    lane_r.range_cm <= lane_nxt.range_cm;
    lane_r.x <= lane_nxt.x;
    lane_r.y <= lane_nxt.y;
    lane_r.z <= lane_nxt.z;
  end

  assign lane_o = lane_r;

endmodule

// ===== rtl/sp2c_scale.sv =====
module sp2c_scale (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sp2c_pkg::lane_t                       lane_i,
  output logic                                  out_valid,
  output logic signed [sp2c_pkg::COORD_W-1:0]   out_x_cm,
  output logic signed [sp2c_pkg::COORD_W-1:0]   out_y_cm
);

  localparam int Q_W = sp2c_pkg::PROD_W - sp2c_pkg::PROD_SHIFT;

  logic signed [sp2c_pkg::LANE_W-1:0]  range_s;
  logic signed [sp2c_pkg::PROD_W-1:0]  prod_x_nxt;
  logic signed [sp2c_pkg::PROD_W-1:0]  prod_y_nxt;
  logic signed [sp2c_pkg::PROD_W-1:0]  prod_x_r;
  logic signed [sp2c_pkg::PROD_W-1:0]  prod_y_r;
  logic                                flip_r;
  logic                                vld_r;
  logic signed [sp2c_pkg::COORD_W-1:0] x_nxt;
  logic signed [sp2c_pkg::COORD_W-1:0] y_nxt;
  logic signed [sp2c_pkg::COORD_W-1:0] x_r;
  logic signed [sp2c_pkg::COORD_W-1:0] y_r;
  logic                                out_valid_r;

  // Truncate a scaled product toward zero, clamp, and apply the sign.
  function automatic logic signed [sp2c_pkg::COORD_W-1:0] trunc_cm(
    input logic signed [sp2c_pkg::PROD_W-1:0] prod,
    input logic                               negate
  );
    logic [sp2c_pkg::PROD_W-1:0] mag;
    logic [Q_W-1:0]              q;
    logic [sp2c_pkg::COORD_W-1:0] qc;
    logic                        neg;
    mag = prod[sp2c_pkg::PROD_W-1] ? sp2c_pkg::PROD_W'(-prod) : sp2c_pkg::PROD_W'(prod);
    q = mag[sp2c_pkg::PROD_W-1:sp2c_pkg::PROD_SHIFT];
    if (q > Q_W'(sp2c_pkg::OUT_LIMIT)) begin
      qc = sp2c_pkg::COORD_W'(sp2c_pkg::OUT_LIMIT);
    end else begin
      qc = q[sp2c_pkg::COORD_W-1:0];
    end
    neg = prod[sp2c_pkg::PROD_W-1] ^ negate;
    return neg ? -signed'(qc) : signed'(qc);
  endfunction

  // First stage: range in centimeters times cosine and sine.
  always_comb begin
    range_s = signed'(sp2c_pkg::LANE_W'(lane_i.range_cm));
    prod_x_nxt = sp2c_pkg::PROD_W'(range_s) * sp2c_pkg::PROD_W'(lane_i.x);
    prod_y_nxt = sp2c_pkg::PROD_W'(range_s) * sp2c_pkg::PROD_W'(lane_i.y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= lane_i.vld;
    end
    flip_r <= lane_i.flip;
    prod_x_r <= prod_x_nxt;
    prod_y_r <= prod_y_nxt;
  end

  // Second stage: truncation to whole centimeters into the output register.
  always_comb begin
    x_nxt = trunc_cm(prod_x_r, flip_r);
    y_nxt = trunc_cm(prod_y_r, flip_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r;
    end
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_x_cm = x_r;
  assign out_y_cm = y_r;

endmodule

// ===== rtl/sp2c_check.sv =====
module sp2c_check #(
  parameter int LATENCY = sp2c_pkg::CORDIC_STAGES_DEF + 3
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input logic                                out_valid,
  input logic signed [sp2c_pkg::COORD_W-1:0] out_x_cm,
  input logic signed [sp2c_pkg::COORD_W-1:0] out_y_cm,
  input logic                                cfg_valid,
  input logic                                cfg_ready
);

  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] since_rst_r;
  logic [CNT_W-1:0] since_rst_nxt;
  logic             warm;

  // Cycles since reset, saturating once the pipeline has filled.
  always_comb begin
    if (since_rst_r == CNT_W'(LATENCY)) begin
      since_rst_nxt = since_rst_r;
    end else begin
      since_rst_nxt = since_rst_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_rst_r <= '0;
    end else begin
      since_rst_r <= since_rst_nxt;
    end
  end

  assign warm = (since_rst_r == CNT_W'(LATENCY));

  // Every accepted sample yields exactly one result a fixed time later.
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> (out_valid == $past(start && !busy, LATENCY)))
    else $error("result beat does not match an accepted sample");

  // No result beat comes out of a pipeline that was just reset.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    !warm |-> !out_valid)
    else $error("result beat before any sample could reach the output");

  // Coordinates stay within the sensor's reach.
  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_x_cm >= -16'sd25600 && out_x_cm <= 16'sd25600))
    else $error("x coordinate out of range");

  a_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_y_cm >= -16'sd25600 && out_y_cm <= 16'sd25600))
    else $error("y coordinate out of range");

  // A configuration beat is taken only together with its valid.
  a_cfg_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> cfg_valid)
    else $error("configuration beat without valid");

endmodule

bind scan_polar_to_cartesian_core sp2c_check #(
  .LATENCY (((CORDIC_STAGES > sp2c_pkg::ATAN_ENTRIES) ?
             sp2c_pkg::ATAN_ENTRIES : CORDIC_STAGES) + 3)
) u_sp2c_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_x_cm  (out_x_cm),
  .out_y_cm  (out_y_cm),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

// ===== tb/testbench.sv =====
module testbench;

  localparam int PIPE_LAT = sp2c_pkg::CORDIC_STAGES_DEF + 3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 100;
  localparam int RAND_PHASES = 8;
  localparam int RAND_PER_PHASE = 250;

  // Register indexes that decode to nothing; writes to them must change nothing.
  localparam logic [sp2c_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [sp2c_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Rotation constants: gain-corrected unit vector in Q2.30 and atan(2^-i)
  // with 2^32 units per turn.
  localparam longint UNIT_GAIN = 64'sd652032874;
  localparam int ATAN_COUNT = 24;
  localparam longint ATAN_TAB [ATAN_COUNT] = '{
    64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
    64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
    64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
    64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861,
    64'sd10430,     64'sd5215,      64'sd2608,      64'sd1304,
    64'sd652,       64'sd326,       64'sd163,       64'sd81
  };

  typedef struct packed {
    logic [sp2c_pkg::RANGE_W-1:0] range_q;
    logic [sp2c_pkg::INDEX_W-1:0] index;
  } scan_beat_t;

  typedef struct packed {
    scan_beat_t         src;
    logic signed [15:0] x_cm;
    logic signed [15:0] y_cm;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [sp2c_pkg::RANGE_W-1:0] in_range_q = '0;
  logic [sp2c_pkg::INDEX_W-1:0] in_sample_index = '0;
  logic out_valid;
  logic signed [sp2c_pkg::COORD_W-1:0] out_x_cm;
  logic signed [sp2c_pkg::COORD_W-1:0] out_y_cm;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sp2c_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sp2c_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  scan_beat_t pending_beats[$];
  point_t expected_points[$];
  logic [sp2c_pkg::ANGLE_W-1:0] angle_start_copy = sp2c_pkg::ANGLE_START_RST;
  logic [sp2c_pkg::ANGLE_W-1:0] angle_step_copy = sp2c_pkg::ANGLE_STEP_RST;
  int mismatches = 0;
  int cycles = 0;
  int burst_left = 1;
  int gap_left = 0;

  scan_polar_to_cartesian_core u_top (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_range_q(in_range_q),
    .in_sample_index(in_sample_index),
    .out_valid(out_valid),
    .out_x_cm(out_x_cm),
    .out_y_cm(out_y_cm),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scale a range by 100 and a Q2.30 trig value, truncating toward zero.
  function automatic logic signed [15:0] scale_to_cm(longint rng, longint trig);
    longint prod;
    longint mag;
    longint q;
    prod = rng * 100 * trig;
    mag = (prod < 0) ? -prod : prod;
    q = mag >> 46;
    if (q > sp2c_pkg::OUT_LIMIT) q = sp2c_pkg::OUT_LIMIT;
    return (prod < 0) ? 16'(-q) : 16'(q);
  endfunction

  // Work out the Cartesian point for one beat under the current registers.
  function automatic point_t polar_to_point(scan_beat_t b);
    logic [sp2c_pkg::RANGE_W-1:0] rng;
    int idx;
    logic [31:0] offset;
    logic [sp2c_pkg::ANGLE_W-1:0] ang;
    logic [sp2c_pkg::ANGLE_W-1:0] shifted;
    logic flip;
    longint cx, cy, cz, dx, dy;
    int stages;
    point_t p;
    rng = b.range_q;
    if (rng <= sp2c_pkg::RANGE_MIN_RAW) rng = sp2c_pkg::RANGE_SUBST_RAW;
    idx = b.index;
    if (idx >= sp2c_pkg::MAX_SAMPLES_DEF) idx = sp2c_pkg::MAX_SAMPLES_DEF - 1;
    offset = 32'(idx) * {16'd0, angle_step_copy};
    ang = angle_start_copy + offset[15:0];
    // Angles in the back half-turn are rotated forward and negated after.
    shifted = ang + sp2c_pkg::QUARTER_TURN;
    flip = shifted[15];
    if (flip) ang = ang ^ sp2c_pkg::HALF_TURN;
    cx = UNIT_GAIN;
    cy = 0;
    cz = longint'($signed(ang)) * 65536;
    stages = (sp2c_pkg::CORDIC_STAGES_DEF > ATAN_COUNT) ? ATAN_COUNT :
             sp2c_pkg::CORDIC_STAGES_DEF;
    for (int i = 0; i < stages; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx = cx - dx;
        cy = cy + dy;
        cz = cz - ATAN_TAB[i];
      end else begin
        cx = cx + dx;
        cy = cy - dy;
        cz = cz + ATAN_TAB[i];
      end
    end
    if (flip) begin
      cx = -cx;
      cy = -cy;
    end
    p.src = b;
    p.x_cm = scale_to_cm(longint'(rng), cx);
    p.y_cm = scale_to_cm(longint'(rng), cy);
    return p;
  endfunction

  task automatic report_mismatch(string line);
    if (mismatches < PRINT_LIMIT)
      $display("%s", line);
    mismatches++;
  endtask

  // Sender: feeds queued beats in bursts with random gaps in between.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy)
        expected_points.insert(expected_points.size(),
                               polar_to_point('{in_range_q, in_sample_index}));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          scan_beat_t b;
          b = pending_beats.pop_front();
          start <= 1'b1;
          in_range_q <= b.range_q;
          in_sample_index <= b.index;
          burst_left--;
          if (burst_left <= 0) begin
            case ($urandom_range(0, 3))
              0: begin
                gap_left = 0;
                burst_left = $urandom_range(50, 200);
              end
              1: begin
                gap_left = $urandom_range(5, 12);
                burst_left = $urandom_range(1, 4);
              end
              default: begin
                gap_left = $urandom_range(1, 4);
                burst_left = $urandom_range(1, 20);
              end
            endcase
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Checker: every result beat must match the oldest outstanding point.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_points.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat: x_cm=%0d y_cm=%0d",
                                  out_x_cm, out_y_cm));
      end else begin
        point_t p;
        p = expected_points.pop_front();
        if (out_x_cm !== p.x_cm)
          report_mismatch($sformatf("mismatch x_cm: range_q=%0d index=%0d expected %0d got %0d",
                                    p.src.range_q, p.src.index, p.x_cm, out_x_cm));
        if (out_y_cm !== p.y_cm)
          report_mismatch($sformatf("mismatch y_cm: range_q=%0d index=%0d expected %0d got %0d",
                                    p.src.range_q, p.src.index, p.y_cm, out_y_cm));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_beat(logic [sp2c_pkg::RANGE_W-1:0] rng,
                            logic [sp2c_pkg::INDEX_W-1:0] idx);
    scan_beat_t b;
    b.range_q = rng;
    b.index = idx;
    pending_beats.insert(pending_beats.size(), b);
  endtask

  // Random beat, weighted toward the small-range threshold and the top of range.
  function automatic scan_beat_t random_beat();
    scan_beat_t b;
    case ($urandom_range(0, 7))
      0: b.range_q = sp2c_pkg::RANGE_W'($urandom_range(0, 700));
      1: b.range_q = 24'hFFFFFF - sp2c_pkg::RANGE_W'($urandom_range(0, 255));
      default: b.range_q = sp2c_pkg::RANGE_W'($urandom());
    endcase
    b.index = sp2c_pkg::INDEX_W'($urandom());
    return b;
  endfunction

  // Hold off until the sender is empty and every point has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (pending_beats.size() != 0 || start || expected_points.size() != 0)
      @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(logic [sp2c_pkg::CFG_IDX_W-1:0] idx,
                           logic [sp2c_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      sp2c_pkg::REG_ANGLE_START: angle_start_copy = val;
      sp2c_pkg::REG_ANGLE_STEP: angle_step_copy = val;
      default: ;
    endcase
  endtask

  task automatic set_angles(logic [sp2c_pkg::ANGLE_W-1:0] first,
                            logic [sp2c_pkg::ANGLE_W-1:0] step);
    wait_drained();
    write_reg(sp2c_pkg::REG_ANGLE_START, first);
    write_reg(sp2c_pkg::REG_ANGLE_STEP, step);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [sp2c_pkg::ANGLE_W-1:0] first;
    logic [sp2c_pkg::ANGLE_W-1:0] step;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers: small ranges, full scale and alternating bit patterns.
    queue_beat(24'd0, 12'd0);
    queue_beat(24'd655, 12'd1);
    queue_beat(24'd656, 12'd2);
    queue_beat(24'hFFFFFF, 12'd4095);
    queue_beat(24'd65536, 12'd0);
    queue_beat(24'h800000, 12'd2048);
    queue_beat(24'd1, 12'd4095);
    queue_beat(24'h555555, 12'hAAA);
    queue_beat(24'hAAAAAA, 12'h555);

    // Exact eighth turns, the quarter-turn boundaries among them.
    set_angles(16'h0000, 16'h1000);
    queue_beat(24'hFFFFFF, 12'd0);
    queue_beat(24'hFFFFFF, 12'd4);
    queue_beat(24'hFFFFFF, 12'd8);
    queue_beat(24'hFFFFFF, 12'd12);
    queue_beat(24'hFFFFFF, 12'd2);
    queue_beat(24'hFFFFFF, 12'd6);

    // One unit either side of the front/back boundaries.
    set_angles(16'h3FFF, 16'd1);
    for (int i = 0; i < 3; i++) queue_beat(24'hFFFFFF, sp2c_pkg::INDEX_W'(i));
    set_angles(16'hBFFF, 16'd1);
    for (int i = 0; i < 3; i++) queue_beat(24'hFFFFFF, sp2c_pkg::INDEX_W'(i));

    // Writes to undecoded indexes must leave the angle registers alone.
    wait_drained();
    write_reg(REG_SPARE_A, sp2c_pkg::CFG_DATA_W'($urandom()));
    write_reg(REG_SPARE_B, sp2c_pkg::CFG_DATA_W'($urandom()));
    @(negedge clk);
    queue_beat(24'd131072, 12'd3);

    // Random phases over several register settings, extremes first.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0: begin first = 16'h8000; step = 16'h0000; end
        1: begin first = 16'h7FFF; step = 16'hFFFF; end
        2: begin first = 16'h0000; step = 16'd1; end
        3: begin first = sp2c_pkg::ANGLE_START_RST; step = sp2c_pkg::ANGLE_STEP_RST; end
        default: begin
          first = sp2c_pkg::ANGLE_W'($urandom());
          step = sp2c_pkg::ANGLE_W'($urandom());
        end
      endcase
      wait_drained();
      if (ph % 2 == 1) begin
        write_reg(sp2c_pkg::REG_ANGLE_STEP, step);
        write_reg(sp2c_pkg::REG_ANGLE_START, first);
      end else begin
        write_reg(sp2c_pkg::REG_ANGLE_START, first);
        write_reg(sp2c_pkg::REG_ANGLE_STEP, step);
      end
      if (ph >= 4)
        write_reg(REG_SPARE_A + sp2c_pkg::CFG_IDX_W'($urandom_range(0, 1)),
                  sp2c_pkg::CFG_DATA_W'($urandom()));
      @(negedge clk);
      for (int n = 0; n < RAND_PER_PHASE; n++)
        pending_beats.insert(pending_beats.size(), random_beat());
    end

    wait_drained();
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
